@@ src/edn_pkg.sv @@
// ----------------------------------------------------------------------------
// edn_pkg: shared types and constants for the edit distance nearest match
// Opcodes, beat structs and sizing for the front/back split.
// ----------------------------------------------------------------------------
package edn_pkg;

  localparam int MaxLen   = 32;
  localparam int MaxCands = 16;
  localparam int LenW     = $clog2(MaxLen + 1);
  localparam int IdxW     = $clog2(MaxLen);
  localparam int CntW     = $clog2(MaxCands + 1);
  localparam int DistW    = 6;
  localparam int QDepth   = 4;
  localparam int QPtrW    = $clog2(QDepth);

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_QCHAR = 3'd1;
  localparam logic [2:0] OP_CCHAR = 3'd2;
  localparam logic [2:0] OP_CEND  = 3'd3;
  localparam logic [2:0] OP_LEND  = 3'd4;

  localparam logic [DistW-1:0] DistSat = '1;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
  } in_beat_t;

  typedef struct packed {
    logic             kind;
    logic [DistW-1:0] distance;
    logic [3:0]       cand_index;
    logic [3:0]       best_index;
    logic [DistW-1:0] best_distance;
    logic             found;
    logic             truncated;
  } out_beat_t;

  // classified command from front to back
  typedef struct packed {
    logic [2:0] op;
    logic [7:0] ch;
  } cmd_t;

endpackage

@@ src/edn_front.sv @@
// ----------------------------------------------------------------------------
// edn_front: input side with a short command queue
// Accepts input beats, drops unknown opcodes and buffers the rest.
// ----------------------------------------------------------------------------
module edn_front
  import edn_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_beat_t in_data,
  output logic     cmd_valid,
  input  logic     cmd_take,
  output cmd_t     cmd
);

  cmd_t             q_r [QDepth];
  logic [QPtrW-1:0] wr_r, rd_r;
  logic [QPtrW:0]   cnt_r;
  logic             push, keep;

  assign in_stall  = (cnt_r == (QPtrW+1)'(QDepth));
  assign keep      = (in_data.op <= OP_LEND);
  assign push      = in_valid && !in_stall && keep;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_r];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= '{op: in_data.op, ch: in_data.ch};
    end
  end

  // queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (cmd_take) rd_r <= rd_r + 1'b1;
      cnt_r <= cnt_r + (QPtrW+1)'(push) - (QPtrW+1)'(cmd_take);
    end
  end

  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_take |-> cmd_valid) else $error("take from empty queue");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (QPtrW+1)'(QDepth)) else $error("queue overflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == (QPtrW+1)'(QDepth)) |-> in_stall) else $error("full not stalled");

endmodule

@@ src/edn_back.sv @@
// ----------------------------------------------------------------------------
// edn_back: DP row engine and result register
// Updates the edit distance row with one query cell per cycle.
// ----------------------------------------------------------------------------
module edn_back
  import edn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  output logic      cmd_take,
  input  cmd_t      cmd,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ROW  = 2'd1;

  logic [1:0]       st_r, st_nxt;
  logic [7:0]       qch_r [MaxLen];
  // row cells 1..MaxLen; cell 0 always equals the kept candidate length
  logic [DistW-1:0] row_r [MaxLen];
  logic             rv_r [MaxLen];
  logic [LenW-1:0]  qlen_r, clen_r;
  logic [CntW-1:0]  ccnt_r;
  logic [3:0]       bidx_r;
  logic [DistW-1:0] bdist_r, diag_r;
  logic             found_r, trunc_r;
  logic [7:0]       cch_r;
  logic [LenW-1:0]  i_r;
  logic             out_hold, emit;
  logic [IdxW-1:0]  cell_idx;
  out_beat_t        od_r;

  logic [DistW-1:0] rd_i, rd_im1, nval, m1, cand_dist, ent;
  logic             accept;

  // row entries read as their index until rewritten
  function automatic logic [DistW-1:0] rowv(input logic v, input logic [DistW-1:0] d,
                                            input int k);
    return v ? d : DistSat & DistW'(k);
  endfunction

  assign cell_idx = i_r[IdxW-1:0] - 1'b1;

  always_comb begin
    rd_i   = '0;
    rd_im1 = DistW'(clen_r);
    ent    = DistW'(clen_r);
    for (int k = 1; k <= MaxLen; k++) begin
      if (LenW'(k) == i_r) rd_i = rowv(rv_r[k-1], row_r[k-1], k);
      if (LenW'(k) == i_r - 1'b1) rd_im1 = rowv(rv_r[k-1], row_r[k-1], k);
      if (LenW'(k) == qlen_r) ent = rowv(rv_r[k-1], row_r[k-1], k);
    end
    m1   = (rd_i < rd_im1) ? rd_i : rd_im1;
    m1   = (m1 < diag_r) ? m1 : diag_r;
    nval = (qch_r[cell_idx] == cch_r) ? diag_r : m1 + 1'b1;
    cand_dist = ent;
    accept = (!found_r || cand_dist < bdist_r) &&
             ({1'b0, cand_dist} <= {1'b0, DistW'(clen_r >> 1)});
  end

  assign out_hold = out_valid && out_stall;
  assign cmd_take = cmd_valid && (st_r == ST_IDLE) && !out_hold;
  assign emit     = cmd_take && (cmd.op == OP_LEND ||
                    (cmd.op == OP_CEND && ccnt_r < CntW'(MaxCands)));
  assign out_data = od_r;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (cmd_take && cmd.op == OP_CCHAR && clen_r < LenW'(MaxLen) &&
                   qlen_r != '0) st_nxt = ST_ROW;
      ST_ROW:  if (i_r == qlen_r) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  // query store and row cells
  always_ff @(posedge clk) begin
    if (cmd_take && cmd.op == OP_QCHAR && qlen_r < LenW'(MaxLen))
      qch_r[qlen_r[IdxW-1:0]] <= cmd.ch;
    if (cmd_take && cmd.op == OP_CCHAR) begin
      cch_r  <= cmd.ch;
      diag_r <= DistW'(clen_r);
      i_r    <= LenW'(1);
    end
    if (st_r == ST_ROW) begin
      row_r[cell_idx] <= nval;
      diag_r          <= rd_i;
      i_r             <= i_r + 1'b1;
    end
  end

  // control and search state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      qlen_r <= '0; clen_r <= '0; ccnt_r <= '0;
      bidx_r <= '0; bdist_r <= DistSat; found_r <= 1'b0; trunc_r <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < MaxLen; k++) rv_r[k] <= 1'b0;
    end else begin
      st_r <= st_nxt;
      out_valid <= emit || out_hold;
      if (st_r == ST_ROW) rv_r[cell_idx] <= 1'b1;
      if (cmd_take) begin
        case (cmd.op)
          OP_START: begin
            qlen_r <= '0; clen_r <= '0; ccnt_r <= '0;
            bidx_r <= '0; bdist_r <= DistSat; found_r <= 1'b0; trunc_r <= 1'b0;
            for (int k = 0; k < MaxLen; k++) rv_r[k] <= 1'b0;
          end
          OP_QCHAR: begin
            if (qlen_r < LenW'(MaxLen)) qlen_r <= qlen_r + 1'b1;
            else trunc_r <= 1'b1;
          end
          OP_CCHAR: begin
            if (clen_r < LenW'(MaxLen)) clen_r <= clen_r + 1'b1;
            else trunc_r <= 1'b1;
          end
          OP_CEND: begin
            clen_r <= '0;
            for (int k = 0; k < MaxLen; k++) rv_r[k] <= 1'b0;
            if (ccnt_r >= CntW'(MaxCands)) trunc_r <= 1'b1;
            else begin
              ccnt_r <= ccnt_r + 1'b1;
              if (accept) begin
                found_r <= 1'b1; bdist_r <= cand_dist; bidx_r <= ccnt_r[3:0];
              end
              od_r <= '{kind: 1'b0, distance: cand_dist, cand_index: ccnt_r[3:0],
                        best_index: accept ? ccnt_r[3:0] : bidx_r,
                        best_distance: accept ? cand_dist : bdist_r,
                        found: accept | found_r, truncated: trunc_r};
            end
          end
          OP_LEND: begin
            clen_r <= '0;
            for (int k = 0; k < MaxLen; k++) rv_r[k] <= 1'b0;
            od_r <= '{kind: 1'b1, distance: '0, cand_index: '0, best_index: bidx_r,
                      best_distance: bdist_r, found: found_r, truncated: trunc_r};
          end
          default: ;
        endcase
      end
    end
  end

  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROW) |-> (i_r <= qlen_r && i_r != '0)) else $error("row index out of range");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ROW) |-> !cmd_take) else $error("command taken mid row");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");

endmodule

@@ src/edit_distance_nearest_match.sv @@
// ----------------------------------------------------------------------------
// edit_distance_nearest_match: nearest candidate by Levenshtein distance
// Front queue classifies beats; back engine walks the DP row.
// ----------------------------------------------------------------------------
// flow: a beat passes through the front queue to the row engine, and its result is
// registered when the engine takes it
// engine use: a candidate char holds the engine while it walks the query row (one cell
// per cycle); other beats do not; a stalled result holds the engine
// reset: synchronous active-low rst_n; row reads as its index, no best found
module edit_distance_nearest_match
  import edn_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_beat_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_beat_t out_data
);

  logic cmd_valid, cmd_take;
  cmd_t cmd;

  edn_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .cmd_valid, .cmd_take, .cmd
  );

  edn_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_stall, .out_data
  );

endmodule

@@ test/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for edit_distance_nearest_match
// Directed table then random searches, scored against a local edit distance
// predictor; random idle and stall on both channels.
// ----------------------------------------------------------------------------
module tb
  import edn_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;

  edit_distance_nearest_match i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [7:0]       qry [MaxLen];
  int unsigned      qry_len, row_len, cand_cnt, best_i, best_d;
  int unsigned      dist_row [MaxLen+1];
  bit               found_f, trunc_f;
  out_beat_t        pending_results [$];
  int               n_errors = 0;
  bit               drive_done = 0;

  // stimulus table: beat plus optional typed-in result
  typedef struct {
    in_beat_t  beat;
    bit        typed;
    out_beat_t res;
  } row_t;
  row_t dir_rows [$];

  task automatic clear_dist_row();
    for (int i = 0; i <= MaxLen; i++) dist_row[i] = i;
    row_len = 0;
  endtask

  task automatic reset_search();
    qry_len = 0; clear_dist_row(); cand_cnt = 0;
    best_i = 0; best_d = DistSat; found_f = 0; trunc_f = 0;
  endtask

  function automatic out_beat_t make_result(bit kind, int unsigned d, int unsigned idx);
    out_beat_t r;
    r.kind = kind;
    r.distance = (d > 63) ? 6'd63 : d[5:0];
    r.cand_index = idx[3:0];
    r.best_index = best_i[3:0];
    r.best_distance = (best_d > 63) ? 6'd63 : best_d[5:0];
    r.found = found_f;
    r.truncated = trunc_f;
    return r;
  endfunction

  // append one expected result beat
  task automatic queue_result(out_beat_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // advance the edit distance search by one beat, queue any result
  task automatic predict_search(in_beat_t b);
    int unsigned diag, nxt, d, m;
    case (b.op)
      OP_START: reset_search();
      OP_QCHAR: begin
        if (qry_len < MaxLen) begin
          qry[qry_len] = b.ch; qry_len++;
        end else trunc_f = 1;
      end
      OP_CCHAR: begin
        if (row_len >= MaxLen) trunc_f = 1;
        else begin
          diag = dist_row[0];
          dist_row[0] = row_len + 1;
          for (int i = 1; i <= qry_len; i++) begin
            if (qry[i-1] == b.ch) nxt = diag;
            else begin
              m = dist_row[i];
              if (dist_row[i-1] < m) m = dist_row[i-1];
              if (diag < m) m = diag;
              nxt = m + 1;
            end
            diag = dist_row[i];
            dist_row[i] = nxt;
          end
          row_len++;
        end
      end
      OP_CEND: begin
        if (cand_cnt >= MaxCands) begin
          trunc_f = 1; clear_dist_row();
        end else begin
          d = dist_row[qry_len];
          if ((!found_f || d < best_d) && d <= row_len / 2) begin
            found_f = 1; best_d = d; best_i = cand_cnt;
          end
          queue_result(make_result(1'b0, d, cand_cnt));
          cand_cnt++;
          clear_dist_row();
        end
      end
      OP_LEND: begin
        clear_dist_row();
        queue_result(make_result(1'b1, 0, 0));
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(string what, out_beat_t got, out_beat_t want);
    $display("mismatch %s: got %p want %p", what, got, want);
    n_errors++;
  endtask

  // beat sender
  task automatic send_beat(in_beat_t b);
    int gap;
    gap = $urandom_range(0, 10);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_search(b);
  endtask

  function automatic in_beat_t mk(logic [2:0] op, logic [7:0] ch);
    in_beat_t b;
    b.op = op; b.ch = ch;
    return b;
  endfunction

  task automatic add_row(logic [2:0] op, logic [7:0] ch);
    row_t r;
    r.beat = mk(op, ch); r.typed = 0; r.res = '0;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic add_typed(logic [2:0] op, out_beat_t res);
    row_t r;
    r.beat = mk(op, 8'h00); r.typed = 1; r.res = res;
    dir_rows.insert(dir_rows.size(), r);
  endtask

  // random char, from a small alphabet unless wide, so matches happen
  function automatic logic [7:0] rand_ch(bit wide);
    return wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h61, 8'h64));
  endfunction

  initial begin
    out_beat_t t;
    int n_items, qlen, nc, cl;
    bit wide;
    logic [7:0] qs [MaxLen];
    reset_search();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty end list after reset, empty candidate, extremes
    t = '0; t.kind = 1; t.best_distance = DistSat;
    add_typed(OP_LEND, t);
    t = '0; t.best_distance = 6'd0; t.found = 1;
    add_typed(OP_CEND, t);                  // empty candidate, empty query
    add_row(OP_START, 8'hff);
    add_row(OP_QCHAR, 8'h00);
    add_row(OP_QCHAR, 8'hff);
    add_row(OP_CCHAR, 8'hff);
    add_row(OP_CCHAR, 8'h00);
    add_row(OP_CEND, 8'h00);
    add_row(OP_CCHAR, 8'h00);
    add_row(OP_CCHAR, 8'hff);
    add_row(OP_CEND, 8'hff);
    add_row(OP_CEND, 8'h00);                // empty candidate, nonzero query
    add_row(3'd5, 8'h12);
    add_row(3'd6, 8'h34);
    add_row(3'd7, 8'h56);
    add_row(OP_CCHAR, 8'h00);
    add_row(OP_QCHAR, 8'h55);               // query grows mid candidate
    add_row(OP_CCHAR, 8'h55);
    add_row(OP_CEND, 8'h00);
    add_row(OP_CCHAR, 8'h01);               // partial candidate dropped
    add_row(OP_LEND, 8'h00);
    add_row(OP_START, 8'h00);
    foreach (dir_rows[k]) begin
      send_beat(dir_rows[k].beat);
      if (dir_rows[k].typed)
        pending_results[pending_results.size() - 1] = dir_rows[k].res;
    end

    // random searches
    n_items = 0;
    while (n_items < 900) begin
      wide = $urandom_range(0, 3) == 0;
      send_beat(mk(OP_START, rand_ch(1)));
      qlen = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 36) : $urandom_range(0, 6);
      for (int i = 0; i < qlen; i++) begin
        qs[i % MaxLen] = rand_ch(wide);
        send_beat(mk(OP_QCHAR, qs[i % MaxLen]));
      end
      n_items += qlen + 1;
      nc = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 19) : $urandom_range(1, 5);
      for (int c = 0; c < nc; c++) begin
        cl = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 35) : $urandom_range(0, 7);
        for (int i = 0; i < cl; i++) begin
          // near copies of the query, with mutations
          if (qlen > 0 && i < qlen && i < MaxLen && $urandom_range(0, 3) != 0)
            send_beat(mk(OP_CCHAR, qs[i]));
          else send_beat(mk(OP_CCHAR, rand_ch(wide)));
          if ($urandom_range(0, 40) == 0) send_beat(mk(OP_QCHAR, rand_ch(wide)));
          if ($urandom_range(0, 60) == 0) send_beat(mk(3'($urandom_range(5, 7)), rand_ch(1)));
        end
        send_beat(mk(OP_CEND, rand_ch(1)));
        n_items += cl + 1;
      end
      if ($urandom_range(0, 5) == 0) send_beat(mk(OP_CCHAR, rand_ch(1)));
      send_beat(mk(OP_LEND, rand_ch(1)));
      n_items++;
    end
    in_valid <= 1'b0;
    drive_done = 1;
  end

  // result receiver: random stall, compare against oldest expectation
  initial begin
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("unexpected beat", out_data, '0);
        end else begin
          out_beat_t want;
          want = pending_results.pop_front();
          if (out_data.kind !== want.kind) report_mismatch("kind", out_data, want);
          if (out_data.distance !== want.distance)
            report_mismatch("distance", out_data, want);
          if (out_data.cand_index !== want.cand_index)
            report_mismatch("cand_index", out_data, want);
          if (out_data.best_index !== want.best_index)
            report_mismatch("best_index", out_data, want);
          if (out_data.best_distance !== want.best_distance)
            report_mismatch("best_distance", out_data, want);
          if (out_data.found !== want.found) report_mismatch("found", out_data, want);
          if (out_data.truncated !== want.truncated)
            report_mismatch("truncated", out_data, want);
        end
      end
      // next stall decision, a fresh draw per beat
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (out_valid && !out_stall) begin
        hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        out_stall <= (hold > 0);
        if (hold > 0) hold--;
      end else out_stall <= 1'b0;
    end
  end

  // end of run
  initial begin
    wait (drive_done);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (n_errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end
endmodule
